### hdl/ezvad_pkg.sv
// Shared constants, types and register codes for the energy / zero-crossing
// voice activity detector.
// No dependencies; compile first.
package ezvad_pkg;

    localparam int ACCUMULATORS = 4;
    localparam int MAX_FRAME    = 1024;
    localparam int SAMPLE_BITS  = 16;

    localparam int LEN_W      = 11;
    localparam int CNT_W      = 10;
    localparam int SQ_W       = 31;
    localparam int SUM_W      = 41;
    localparam int THR_W      = 31;
    localparam int ZCR_W      = 17;
    localparam int SENS_W     = 9;
    localparam int MODE_W     = 2;
    localparam int HANG_W     = 8;
    localparam int SCALE_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Square of the sample magnitude, rescaled to Q1.30
    localparam int SQ_FULL_W = 2 * (SAMPLE_BITS + 1);
    localparam int SQ_RSH    = (SAMPLE_BITS > 16) ? 2 * (SAMPLE_BITS - 16) : 0;
    localparam int SQ_LSH    = (SAMPLE_BITS < 16) ? 2 * (16 - SAMPLE_BITS) : 0;

    // Threshold scaling
    localparam int SENS_FULL = 256;
    localparam int SCALE_ONE = 512;
    localparam int E_SHIFT   = 9;
    localparam int Z_SHIFT   = 25;
    localparam int PE_W      = THR_W + SCALE_W;
    localparam int PZ_W      = ZCR_W + SCALE_W;
    localparam int ERHS_W    = PE_W + LEN_W;
    localparam int ZRHS_W    = PZ_W + LEN_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_LENGTH     = 3'd0,
        REG_FRAME_SHIFT      = 3'd1,
        REG_ENERGY_THRESHOLD = 3'd2,
        REG_ZCR_THRESHOLD    = 3'd3,
        REG_SENSITIVITY      = 3'd4,
        REG_COMBINE_MODE     = 3'd5,
        REG_HANGOVER_FRAMES  = 3'd6
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENERGY = 2'd0,
        MODE_EITHER = 2'd1,
        MODE_ZCR    = 2'd2
    } mode_t;

    typedef struct packed {
        logic [LEN_W-1:0] frame_length;
        logic [LEN_W-1:0] frame_shift;
    } front_cfg_t;

    typedef struct packed {
        logic [THR_W-1:0]  energy_threshold;
        logic [ZCR_W-1:0]  zcr_threshold;
        logic [SENS_W-1:0] sensitivity;
        mode_t             combine_mode;
        logic [HANG_W-1:0] hangover_frames;
    } back_cfg_t;

    // One completed frame as handed from the lanes to the decision pipeline
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] crossings;
        logic [LEN_W-1:0] samples;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic valid;
    } fifo_status_t;

endpackage

### hdl/ezvad_front.sv
// Front end: frame scheduler and accumulator lanes, one sample per cycle while the frame queue has room.
// Depends on ezvad_pkg.
module ezvad_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ezvad_pkg::front_cfg_t                  cfg,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [ezvad_pkg::SAMPLE_BITS-1:0] sample,
    input  ezvad_pkg::fifo_status_t                q_status,
    output logic                                   push,
    output ezvad_pkg::frame_rec_t                  rec
);
    import ezvad_pkg::*;

    logic [ACCUMULATORS-1:0] busy_reg;
    logic [ACCUMULATORS-1:0] busy_next;
    logic [SUM_W-1:0]        sum_reg        [ACCUMULATORS];
    logic [SUM_W-1:0]        sum_next       [ACCUMULATORS];
    logic [CNT_W-1:0]        cross_reg      [ACCUMULATORS];
    logic [CNT_W-1:0]        cross_next     [ACCUMULATORS];
    logic [LEN_W-1:0]        count_reg      [ACCUMULATORS];
    logic [LEN_W-1:0]        count_next     [ACCUMULATORS];
    logic [ACCUMULATORS-1:0] start_lane;
    logic [ACCUMULATORS-1:0] lane_on;
    logic [ACCUMULATORS-1:0] retire;

    logic [LEN_W-1:0] shift_cnt_reg;
    logic [LEN_W-1:0] shift_cnt_next;
    logic             prev_sign_reg;

    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] eff_shift;
    logic [LEN_W-1:0] min_shift;
    logic [LEN_W-1:0] sc_now;
    logic [LEN_W-1:0] sc_inc;
    logic             accept;
    logic             neg;

    logic signed [SAMPLE_BITS:0] sample_x;
    logic [SAMPLE_BITS:0]        mag;
    logic [SQ_FULL_W-1:0]        sq_full;
    logic [SQ_W-1:0]             sq;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign neg      = sample[SAMPLE_BITS-1];

    // Effective frame length and shift after clamping
    always_comb
    begin
        eff_len = cfg.frame_length;
        if (eff_len < LEN_W'(2))
            eff_len = LEN_W'(2);
        if (eff_len > LEN_W'(MAX_FRAME))
            eff_len = LEN_W'(MAX_FRAME);
        min_shift = LEN_W'((eff_len + LEN_W'(ACCUMULATORS - 1)) / ACCUMULATORS);
        eff_shift = cfg.frame_shift;
        if (eff_shift < LEN_W'(1))
            eff_shift = LEN_W'(1);
        if (eff_shift > LEN_W'(MAX_FRAME))
            eff_shift = LEN_W'(MAX_FRAME);
        if (eff_shift < min_shift)
            eff_shift = min_shift;
    end

    // Squared magnitude
    assign sample_x = {sample[SAMPLE_BITS-1], sample};
    assign mag      = neg ? $unsigned(-sample_x) : $unsigned(sample_x);
    assign sq_full  = SQ_FULL_W'(mag) * SQ_FULL_W'(mag);
    assign sq       = SQ_W'((64'(sq_full) >> SQ_RSH) << SQ_LSH);

    // Frame start scheduling
    assign sc_now         = (shift_cnt_reg >= eff_shift) ? '0 : shift_cnt_reg;
    assign sc_inc         = sc_now + LEN_W'(1);
    assign shift_cnt_next = (sc_inc >= eff_shift) ? '0 : sc_inc;

    always_comb
    begin
        logic found;
        found = 1'b0;
        for (int i = 0; i < ACCUMULATORS; i++)
        begin
            start_lane[i] = (sc_now == '0) && !busy_reg[i] && !found;
            if (!busy_reg[i])
                found = 1'b1;
        end
    end

    // Per-lane accumulate and retire
    always_comb
    begin
        logic [SUM_W-1:0] base_sum;
        logic [CNT_W-1:0] base_cross;
        logic [LEN_W-1:0] base_count;
        for (int i = 0; i < ACCUMULATORS; i++)
        begin
            lane_on[i] = busy_reg[i] || start_lane[i];
            base_sum   = start_lane[i] ? '0 : sum_reg[i];
            base_cross = start_lane[i] ? '0 : cross_reg[i];
            base_count = start_lane[i] ? '0 : count_reg[i];
            sum_next[i]   = base_sum + SUM_W'(sq);
            cross_next[i] = base_cross;
            if (base_count != '0 && neg != prev_sign_reg && base_cross != CNT_MAX)
                cross_next[i] = base_cross + CNT_W'(1);
            count_next[i] = base_count + LEN_W'(1);
            retire[i]     = lane_on[i] && (count_next[i] >= eff_len);
            busy_next[i]  = lane_on[i] && !retire[i];
        end
    end

    // Only the lowest retiring lane is reported
    always_comb
    begin
        logic found;
        found = 1'b0;
        rec   = '0;
        for (int i = 0; i < ACCUMULATORS; i++)
        begin
            if (retire[i] && !found)
            begin
                rec.sum       = sum_next[i];
                rec.crossings = cross_next[i];
                rec.samples   = count_next[i];
                found         = 1'b1;
            end
        end
    end

    assign push = accept && (retire != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            shift_cnt_reg <= '0;
            prev_sign_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg      <= busy_next;
            shift_cnt_reg <= shift_cnt_next;
            prev_sign_reg <= neg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ACCUMULATORS; i++)
        begin
            if (accept && lane_on[i])
            begin
                sum_reg[i]   <= sum_next[i];
                cross_reg[i] <= cross_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

### hdl/ezvad_fifo.sv
// Small frame-record queue between the lanes and the decision pipeline.
// Depends on ezvad_pkg.
module ezvad_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ezvad_pkg::frame_rec_t   push_rec,
    input  logic                    pop,
    output ezvad_pkg::fifo_status_t status,
    output ezvad_pkg::frame_rec_t   head_rec
);
    import ezvad_pkg::*;

    frame_rec_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.valid = (count_reg != '0);
    assign head_rec     = entry_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && status.valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

### hdl/ezvad_back.sv
// Back end: threshold products, frame tests, mode combine and hangover,
// ending in the output register. Depends on ezvad_pkg.
module ezvad_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ezvad_pkg::back_cfg_t          cfg,
    input  ezvad_pkg::fifo_status_t       q_status,
    input  ezvad_pkg::frame_rec_t         q_rec,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          voice_active,
    output logic                          energy_over,
    output logic                          crossing_under,
    output logic                          held_by_hangover,
    output logic [ezvad_pkg::CNT_W-1:0]   crossing_count
);
    import ezvad_pkg::*;

    logic               adv;
    logic [SENS_W-1:0]  sens_eff;
    logic [SCALE_W-1:0] e_scale;
    logic [SCALE_W-1:0] z_scale;

    // stage 1: config products
    logic               s1_valid_reg;
    logic [PE_W-1:0]    s1_pe_reg;
    logic [PZ_W-1:0]    s1_pz_reg;
    frame_rec_t         s1_rec_reg;

    // stage 2: right-hand sides scaled by frame size
    logic               s2_valid_reg;
    logic [ERHS_W-1:0]  s2_erhs_reg;
    logic [ZRHS_W-1:0]  s2_zrhs_reg;
    logic [SUM_W-1:0]   s2_sum_reg;
    logic [CNT_W-1:0]   s2_cross_reg;
    logic [LEN_W-1:0]   s1_nm1;

    // stage 3: decision
    logic               e_over;
    logic               z_under;
    logic               act_raw;
    logic               act;
    logic               held;
    logic [HANG_W-1:0]  hang_reg;
    logic [HANG_W-1:0]  hang_next;

    logic               out_valid_reg;
    logic               voice_active_reg;
    logic               energy_over_reg;
    logic               crossing_under_reg;
    logic               held_reg;
    logic [CNT_W-1:0]   crossing_count_reg;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = q_status.valid && adv;

    assign sens_eff = (cfg.sensitivity > SENS_W'(SENS_FULL)) ? SENS_W'(SENS_FULL)
                                                             : cfg.sensitivity;
    assign e_scale  = SCALE_W'(SCALE_ONE) - SCALE_W'(sens_eff);
    assign z_scale  = SCALE_W'(SCALE_ONE) + SCALE_W'(sens_eff);
    assign s1_nm1   = s1_rec_reg.samples - LEN_W'(1);

    assign e_over  = (ERHS_W'(s2_sum_reg) << E_SHIFT) > s2_erhs_reg;
    assign z_under = (ZRHS_W'(s2_cross_reg) << Z_SHIFT) < s2_zrhs_reg;

    always_comb
    begin
        unique case (cfg.combine_mode)
            MODE_ENERGY: act_raw = e_over;
            MODE_ZCR:    act_raw = z_under;
            MODE_EITHER: act_raw = e_over || z_under;
            default:     act_raw = e_over || z_under;
        endcase
    end

    always_comb
    begin
        act       = act_raw;
        held      = 1'b0;
        hang_next = hang_reg;
        if (act_raw)
            hang_next = cfg.hangover_frames;
        else if (hang_reg != '0)
        begin
            hang_next = hang_reg - HANG_W'(1);
            act       = 1'b1;
            held      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hang_reg      <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_status.valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
                hang_reg <= hang_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pe_reg          <= PE_W'(cfg.energy_threshold) * PE_W'(e_scale);
            s1_pz_reg          <= PZ_W'(cfg.zcr_threshold) * PZ_W'(z_scale);
            s1_rec_reg         <= q_rec;
            s2_erhs_reg        <= ERHS_W'(s1_pe_reg) * ERHS_W'(s1_rec_reg.samples);
            s2_zrhs_reg        <= ZRHS_W'(s1_pz_reg) * ZRHS_W'(s1_nm1);
            s2_sum_reg         <= s1_rec_reg.sum;
            s2_cross_reg       <= s1_rec_reg.crossings;
            voice_active_reg   <= act;
            energy_over_reg    <= e_over;
            crossing_under_reg <= z_under;
            held_reg           <= held;
            crossing_count_reg <= s2_cross_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign voice_active     = voice_active_reg;
    assign energy_over      = energy_over_reg;
    assign crossing_under   = crossing_under_reg;
    assign held_by_hangover = held_reg;
    assign crossing_count   = crossing_count_reg;

endmodule

### hdl/energy_zcr_voice_activity_detector_unit.sv
// Top level of the energy / zero-crossing voice activity detector.
// Depends on ezvad_pkg, ezvad_front, ezvad_fifo and ezvad_back.
//
//   Channel  Direction  Handshake              Payload
//   -------  ---------  ---------------------  ---------------------------------
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in         in_valid / in_ready    sample (signed Q1.15)
//   out      out        out_valid / out_ready  voice_active, energy_over,
//                                              crossing_under, held_by_hangover,
//                                              crossing_count
//
// Rate: one sample transfer per cycle while in_ready is high, set by the lane update in the front end.
// After the transfer of its last sample, a frame result goes through the queue
// read, product stage, scaling stage and decision into the output reg.
// Reset is asynchronous, active low; config registers return to defaults.
// in_ready drops only while the four-entry frame queue is full; a stalled
// output freezes the back-end pipeline while the lanes keep running.
module energy_zcr_voice_activity_detector_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ezvad_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ezvad_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [ezvad_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   voice_active,
    output logic                                   energy_over,
    output logic                                   crossing_under,
    output logic                                   held_by_hangover,
    output logic [ezvad_pkg::CNT_W-1:0]            crossing_count
);
    import ezvad_pkg::*;

    // Configuration register file
    logic [LEN_W-1:0]  frame_length_reg;
    logic [LEN_W-1:0]  frame_shift_reg;
    logic [THR_W-1:0]  energy_threshold_reg;
    logic [ZCR_W-1:0]  zcr_threshold_reg;
    logic [SENS_W-1:0] sensitivity_reg;
    mode_t             combine_mode_reg;
    logic [HANG_W-1:0] hangover_frames_reg;

    front_cfg_t   front_cfg;
    back_cfg_t    back_cfg;
    fifo_status_t q_status;
    frame_rec_t   push_rec;
    frame_rec_t   head_rec;
    logic         push;
    logic         pop;
    logic         cfg_write;

    // Config writes are always taken; software must write only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg     <= LEN_W'(320);
            frame_shift_reg      <= LEN_W'(160);
            energy_threshold_reg <= THR_W'(53687091);
            zcr_threshold_reg    <= ZCR_W'(13107);
            sensitivity_reg      <= SENS_W'(128);
            combine_mode_reg     <= MODE_EITHER;
            hangover_frames_reg  <= HANG_W'(3);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_LENGTH:     frame_length_reg     <= cfg_data[LEN_W-1:0];
                REG_FRAME_SHIFT:      frame_shift_reg      <= cfg_data[LEN_W-1:0];
                REG_ENERGY_THRESHOLD: energy_threshold_reg <= cfg_data[THR_W-1:0];
                REG_ZCR_THRESHOLD:    zcr_threshold_reg    <= cfg_data[ZCR_W-1:0];
                REG_SENSITIVITY:      sensitivity_reg      <= cfg_data[SENS_W-1:0];
                REG_COMBINE_MODE:     combine_mode_reg     <= mode_t'(cfg_data[MODE_W-1:0]);
                REG_HANGOVER_FRAMES:  hangover_frames_reg  <= cfg_data[HANG_W-1:0];
                default:              ;  // unmapped index: write dropped
            endcase
        end
    end

    assign front_cfg.frame_length = frame_length_reg;
    assign front_cfg.frame_shift  = frame_shift_reg;

    assign back_cfg.energy_threshold = energy_threshold_reg;
    assign back_cfg.zcr_threshold    = zcr_threshold_reg;
    assign back_cfg.sensitivity      = sensitivity_reg;
    assign back_cfg.combine_mode     = combine_mode_reg;
    assign back_cfg.hangover_frames  = hangover_frames_reg;

    // Front end: frame scheduling and per-lane energy / crossing accumulation.
    // Emits one record per completed frame.
    ezvad_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (front_cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .q_status (q_status),
        .push     (push),
        .rec      (push_rec)
    );

    // Decouples the lanes from the decision pipeline so each side stalls alone.
    ezvad_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .status   (q_status),
        .head_rec (head_rec)
    );

    // Back end: scaled threshold tests, mode combine, hangover, output register.
    ezvad_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (back_cfg),
        .q_status         (q_status),
        .q_rec            (head_rec),
        .q_pop            (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .voice_active     (voice_active),
        .energy_over      (energy_over),
        .crossing_under   (crossing_under),
        .held_by_hangover (held_by_hangover),
        .crossing_count   (crossing_count)
    );

endmodule

### hdl/ezvad_checker.sv
// Port-level checks for the voice activity detector top level, plus the
// bind that attaches them. Depends on ezvad_pkg and the top level.
module ezvad_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_ready,
    input logic signed [ezvad_pkg::SAMPLE_BITS-1:0] sample,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic                                   voice_active,
    input logic                                   energy_over,
    input logic                                   crossing_under,
    input logic                                   held_by_hangover,
    input logic [ezvad_pkg::CNT_W-1:0]            crossing_count
);
    import ezvad_pkg::*;

    // A sample offered but not taken stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(sample))
        else $error("input transfer changed while stalled");

    // A result offered but not taken stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(voice_active)
            && $stable(energy_over) && $stable(crossing_under)
            && $stable(held_by_hangover) && $stable(crossing_count))
        else $error("output transfer changed while stalled");

    // A frame held by the hangover counter is always reported active
    a_held_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && held_by_hangover |-> voice_active)
        else $error("held frame reported inactive");

    // Nothing is offered on the first edge after reset release
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered straight out of reset");

endmodule

bind energy_zcr_voice_activity_detector_unit ezvad_checker u_ezvad_checker (.*);
